// ----- hdl/sha512_pkg.sv -----
// Package: SHA-512 constants, round constant table and helper functions.
`timescale 1ns / 1ps
package sha512_pkg;

  localparam int WordW = 64;
  localparam int BlockWords = 16;
  localparam int Rounds = 80;
  localparam int LenPos = 14;

  typedef logic [WordW-1:0] word_t;

  // datapath command from controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH,     // write push_data into window, advance word count
    CMD_START,    // load working vars from hash
    CMD_ROUND,    // run one round
    CMD_FOLD,     // add working vars into hash
    CMD_RESTART   // reload initial hash, clear counters
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    word_t       push_data;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] words;
    logic       last_round;
    word_t      msg_bits;
  } dp_stat_t;

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 64'h6a09e667f3bcc908;
      3'd1: init_hash = 64'hbb67ae8584caa73b;
      3'd2: init_hash = 64'h3c6ef372fe94f82b;
      3'd3: init_hash = 64'ha54ff53a5f1d36f1;
      3'd4: init_hash = 64'h510e527fade682d1;
      3'd5: init_hash = 64'h9b05688c2b3e6c1f;
      3'd6: init_hash = 64'h1f83d9abfb41bd6b;
      default: init_hash = 64'h5be0cd19137e2179;
    endcase
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    case (t)
      7'd0: round_k = 64'h428a2f98d728ae22;  7'd1: round_k = 64'h7137449123ef65cd;
      7'd2: round_k = 64'hb5c0fbcfec4d3b2f;  7'd3: round_k = 64'he9b5dba58189dbbc;
      7'd4: round_k = 64'h3956c25bf348b538;  7'd5: round_k = 64'h59f111f1b605d019;
      7'd6: round_k = 64'h923f82a4af194f9b;  7'd7: round_k = 64'hab1c5ed5da6d8118;
      7'd8: round_k = 64'hd807aa98a3030242;  7'd9: round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; default: round_k = 64'h6c44198c4a475817;
    endcase
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ----- hdl/sha512_if.sv -----
// Interfaces: request and digest valid/ready channels.
`timescale 1ns / 1ps
interface sha512_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;
  modport source (output valid, message_word, valid_bytes, final_word, input ready);
  modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha512_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ----- hdl/sha512_dp.sv -----
// Datapath: hash state, working variables, schedule window, round logic.
`timescale 1ns / 1ps
module sha512_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha512_pkg::dp_cmd_t  cmd,
  input  logic [6:0]           bit_add,
  input  logic [2:0]           rd_idx,
  output sha512_pkg::word_t    rd_hash,
  output sha512_pkg::dp_stat_t stat
);
  import sha512_pkg::*;

  word_t      hash_r [8];
  word_t      var_r [8];
  word_t      win_r [BlockWords];
  logic [3:0] words_r;
  logic [6:0] round_r;
  word_t      bits_r;

  word_t w_new, w_cur, t1, t2, s0, s1, q0, q1, ch, mj, a15, b2;

  always_comb begin
    a15 = win_r[4'(round_r - 7'd15)];
    b2  = win_r[4'(round_r - 7'd2)];
    q0  = rotr(a15, 1) ^ rotr(a15, 8) ^ (a15 >> 7);
    q1  = rotr(b2, 19) ^ rotr(b2, 61) ^ (b2 >> 6);
    w_new = win_r[round_r[3:0]] + q0 + win_r[4'(round_r - 7'd7)] + q1;
    w_cur = (round_r >= 7'(BlockWords)) ? w_new : win_r[round_r[3:0]];
    s1 = rotr(var_r[4], 14) ^ rotr(var_r[4], 18) ^ rotr(var_r[4], 41);
    ch = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    t1 = var_r[7] + s1 + ch + round_k(round_r) + w_cur;
    s0 = rotr(var_r[0], 28) ^ rotr(var_r[0], 34) ^ rotr(var_r[0], 39);
    mj = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= init_hash(3'(i));
        var_r[i]  <= '0;
      end
      words_r <= '0;
      round_r <= '0;
      bits_r  <= '0;
    end else begin
      case (cmd.op)
        CMD_PUSH: begin
          win_r[words_r] <= cmd.push_data;
          words_r        <= words_r + 4'd1;
          bits_r         <= bits_r + WordW'(bit_add);
        end
        CMD_START: begin
          for (int i = 0; i < 8; i++) var_r[i] <= hash_r[i];
          round_r <= '0;
        end
        CMD_ROUND: begin
          win_r[round_r[3:0]] <= w_cur;
          var_r[7] <= var_r[6]; var_r[6] <= var_r[5]; var_r[5] <= var_r[4];
          var_r[4] <= var_r[3] + t1;
          var_r[3] <= var_r[2]; var_r[2] <= var_r[1]; var_r[1] <= var_r[0];
          var_r[0] <= t1 + t2;
          round_r  <= (round_r == 7'(Rounds - 1)) ? 7'd0 : round_r + 7'd1;
        end
        CMD_FOLD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + var_r[i];
        end
        CMD_RESTART: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
          words_r <= '0;
          bits_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign rd_hash         = hash_r[rd_idx];
  assign stat.words      = words_r;
  assign stat.last_round = (round_r == 7'(Rounds - 1));
  assign stat.msg_bits   = bits_r;
endmodule

// ----- hdl/sha512_ctrl.sv -----
// Controller: accepts requests, sequences padding, compression and digest output.
`timescale 1ns / 1ps
module sha512_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  sha512_req_if.sink           req,
  sha512_dig_if.source         dig,
  input  sha512_pkg::dp_stat_t stat,
  input  sha512_pkg::word_t    rd_hash,
  output sha512_pkg::dp_cmd_t  cmd,
  output logic [6:0]           bit_add,
  output logic [2:0]           rd_idx
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    P_MARK, P_ZERO, P_LEN
  } pad_t;

  state_t     state_r, state_nxt;
  pad_t       pad_r, pad_nxt;
  logic       padding_r, padding_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [3:0] nb;
  word_t      keep, last_w;

  always_comb begin
    nb   = (req.valid_bytes > 4'd8) ? 4'd8 : req.valid_bytes;
    keep = (nb == 4'd0) ? '0 : ~(64'hffffffffffffffff >> {nb[3:0], 3'b000});
    last_w = (req.message_word & keep) | (nb == 4'd8 ? '0 :
             (64'h8000000000000000 >> {nb[2:0], 3'b000}));
  end

  assign req.ready = (state_r == S_IDLE);
  assign rd_idx    = idx_r;

  always_comb begin
    state_nxt   = state_r;
    pad_nxt     = pad_r;
    padding_nxt = padding_r;
    idx_nxt     = idx_r;
    ovalid_nxt  = ovalid_r;
    cmd.op        = CMD_NONE;
    cmd.push_data = '0;
    bit_add       = '0;
    case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          cmd.op = CMD_PUSH;
          if (!req.final_word) begin
            cmd.push_data = req.message_word;
            bit_add       = 7'd64;
          end else begin
            cmd.push_data = last_w;
            bit_add       = {nb, 3'b000};
            padding_nxt   = 1'b1;
            pad_nxt       = (nb == 4'd8) ? P_MARK : P_ZERO;
          end
          if (stat.words == 4'd15) state_nxt = S_START;
          else if (req.final_word) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.op = CMD_PUSH;
        case (pad_r)
          P_MARK: begin
            cmd.push_data = 64'h8000000000000000;
            pad_nxt = P_ZERO;
          end
          P_ZERO: begin
            if (stat.words == 4'(LenPos)) pad_nxt = P_LEN;
          end
          default: begin
            cmd.push_data = stat.msg_bits;
          end
        endcase
        if (stat.words == 4'd15) state_nxt = S_START;
      end
      S_START: begin
        cmd.op = CMD_START;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.op = CMD_ROUND;
        if (stat.last_round) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.op = CMD_FOLD;
        if (!padding_r) state_nxt = S_IDLE;
        else if (pad_r == P_LEN) begin
          state_nxt = S_OUT;
          idx_nxt   = '0;
        end else state_nxt = S_PAD;
      end
      S_OUT: begin
        if (!ovalid_r || dig.ready) begin
          if (ovalid_r && idx_r == 3'd7) begin
            ovalid_nxt  = 1'b0;
            cmd.op      = CMD_RESTART;
            padding_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            if (ovalid_r) idx_nxt = idx_r + 3'd1;
            ovalid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pad_r     <= P_MARK;
      padding_r <= 1'b0;
      idx_r     <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pad_r     <= pad_nxt;
      padding_r <= padding_nxt;
      idx_r     <= idx_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // hash is stable during output, so present the indexed word directly
  assign dig.valid        = ovalid_r;
  assign dig.digest_word  = rd_hash;
  assign dig.digest_index = idx_r;
  assign dig.digest_last  = ovalid_r && (idx_r == 3'd7);
endmodule

// ----- hdl/sha512_hash.sv -----
// Top level: SHA-512 hash engine with request and digest channels.
// Usage:
//  - Requests arrive on in_req as 64-bit big-endian message words, valid
//    bytes left-aligned; final_word marks the last word of a message and
//    valid_bytes (0..8, larger values saturate) counts its bytes.
//  - A request is taken each cycle the engine is idle; a word that
//    completes a 1024-bit block starts the 80-round compression, one round
//    a cycle; no request is taken until that block is folded into the hash.
//  - On the final word the engine pads the message itself (one or two
//    blocks), then presents the eight digest words on out_dig, index 0 first,
//    digest_last on index 7. Whether one or two padded blocks are compressed
//    before the first digest word is set by where the final word falls in its block.
//  - While out_dig is stalled the digest word holds and no request is taken.
//  - Synchronous reset loads the initial hash and drops any partial message.
`timescale 1ns / 1ps
module sha512_hash (
  input  logic         clk,
  input  logic         rst_n,
  sha512_req_if.sink   in_req,
  sha512_dig_if.source out_dig
);
  import sha512_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [6:0] bit_add;
  logic [2:0] rd_idx;
  word_t      rd_hash;

  sha512_ctrl u_ctrl (
    .clk, .rst_n, .req(in_req), .dig(out_dig), .stat, .rd_hash,
    .cmd, .bit_add, .rd_idx
  );

  sha512_dp u_dp (
    .clk, .rst_n, .cmd, .bit_add, .rd_idx, .rd_hash, .stat
  );

`ifndef ASSERT_OFF
  // no request is taken while a digest is on the output
  assert property (@(posedge clk) disable iff (!rst_n)
    out_dig.valid |-> !in_req.ready)
    else $error("request taken during digest output");
  // digest index advances only after a completed transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_dig.valid && !out_dig.ready |=> out_dig.valid && $stable(out_dig.digest_index))
    else $error("digest dropped under stall");
`endif
endmodule

// ----- verif/sha512_checker.sv -----
// Checker: predicts SHA-512 digests from accepted requests and compares digest words.
`timescale 1ns / 1ps
module sha512_checker (
  input  logic      clk,
  input  logic      rst_n,
  sha512_req_if     req,
  sha512_dig_if     dig,
  output int        fail_count,
  output int        pending
);
  import sha512_pkg::*;

  typedef struct packed {
    word_t      value;
    logic [2:0] index;
    logic       last;
  } digest_t;

  word_t   hash_state [8];
  word_t   block_buf [16];
  int      block_fill;
  word_t   bit_count;
  digest_t digest_q [$];

  localparam word_t IvTable [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam word_t KTable [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    word_t w [80];
    word_t v [8];
    word_t t1, t2;
    for (int t = 0; t < 80; t++) begin
      if (t < 16) w[t] = block_buf[t];
      else w[t] = w[t-16] + w[t-7]
        + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7))
        + (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6));
    end
    v = hash_state;
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTable[t] + w[t];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic append_word(word_t w);
    block_buf[block_fill] = w;
    block_fill = (block_fill + 1) % 16;
    if (block_fill == 0) compress_block();
  endtask

  task automatic absorb_request(word_t word, logic [3:0] nbytes, logic fin);
    int    nb;
    word_t keep;
    if (!fin) begin
      append_word(word);
      bit_count += 64;
      return;
    end
    nb = (nbytes > 8) ? 8 : nbytes;
    bit_count += word_t'(nb * 8);
    if (nb == 8) begin
      append_word(word);
      append_word(64'h8000000000000000);
    end else begin
      keep = (nb == 0) ? '0 : ~64'h0 << (64 - 8 * nb);
      append_word((word & keep) | (64'h80 << (56 - 8 * nb)));
    end
    while (block_fill != 14) append_word('0);
    append_word('0);
    append_word(bit_count);
    for (int i = 0; i < 8; i++)
      digest_q.push_back('{hash_state[i], 3'(i), i == 7});
    hash_state = IvTable;
    block_fill = 0;
    bit_count = '0;
  endtask

  task automatic report(string what, word_t got, word_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    hash_state = IvTable;
    block_fill = 0;
    bit_count = '0;
  end

  always @(posedge clk) begin
    digest_t want;
    if (rst_n) begin
      if (req.valid && req.ready)
        absorb_request(req.message_word, req.valid_bytes, req.final_word);
      if (dig.valid && dig.ready) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest", dig.digest_word, '0);
        end else begin
          want = digest_q.pop_front();
          if (dig.digest_word !== want.value) report("word", dig.digest_word, want.value);
          if (dig.digest_index !== want.index)
            report("index", 64'(dig.digest_index), 64'(want.index));
          if (dig.digest_last !== want.last)
            report("last", 64'(dig.digest_last), 64'(want.last));
        end
      end
    end
    pending = digest_q.size();
  end
endmodule

// ----- verif/tb_top.sv -----
// Testbench top: drives message requests, stalls the digest side, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;          // long stretch with no idling on either side
  bit   hold_off;      // receiver holds off to back up the engine

  sha512_req_if req ();
  sha512_dig_if dig ();

  sha512_hash dut (.clk(clk), .rst_n(rst_n), .in_req(req.sink), .out_dig(dig.source));

  sha512_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .dig(dig),
                      .fail_count(fail_count), .pending(pending));

  always #1 clk = ~clk;

  // Drive one request; hold valid until accepted, insert random idles first.
  task automatic send_request(logic [63:0] w, logic [3:0] nb, logic fin);
    while (!calm && $urandom_range(99) < 34) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.message_word <= w;
    req.valid_bytes <= nb;
    req.final_word <= fin;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Send a message of full words then a last word with nb bytes.
  task automatic send_message(int full_words, logic [3:0] nb);
    for (int i = 0; i < full_words; i++)
      send_request({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
    send_request({$urandom, $urandom}, nb, 1'b1);
  endtask

  // Receiver: random stalls, one long hold-off, no stalls during the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) dig.ready <= 1'b0;
    else dig.ready <= !hold_off && (calm || $urandom_range(99) >= 34);
  end

  initial begin
    hold_off = 1'b0;
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog: end the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (dig.valid && dig.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int nb;
    int fw;
    idle_cycles = 0;
    calm = 1'b0;
    req.valid = 1'b0;
    req.message_word = '0;
    req.valid_bytes = '0;
    req.final_word = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, all-ones and zero words, every byte count, block edges.
    send_request(64'hffffffffffffffff, 4'd0, 1'b1);
    send_request(64'hffffffffffffffff, 4'd8, 1'b1);
    send_request(64'h0, 4'd15, 1'b1);
    send_request(64'hffffffffffffffff, 4'd9, 1'b0);
    send_request(64'h0123456789abcdef, 4'd3, 1'b1);
    for (int b = 1; b <= 7; b++) send_request(64'hffffffffffffffff, 4'(b), 1'b1);
    send_message(13, 4'd8);   // pad spills into a second block
    send_message(14, 4'd0);

    // Random messages, mostly short, a calm stretch in the middle.
    n = 0;
    while (n < 70) begin
      calm = (n >= 25 && n < 45);
      nb = $urandom_range(9);
      if ($urandom_range(9) == 0) begin
        fw = 15 + $urandom_range(17);
        send_message(fw, 4'(nb));
      end else begin
        fw = $urandom_range(5);
        send_message(fw, 4'(nb == 9 ? $urandom_range(15) : nb));
      end
      n += fw + 1;
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sha512_hash.f -----
hdl/sha512_pkg.sv
hdl/sha512_if.sv
hdl/sha512_dp.sv
hdl/sha512_ctrl.sv
hdl/sha512_hash.sv
verif/sha512_checker.sv
verif/tb_top.sv
